@@ sv/sorted_key_lower_bound_search_defines.svh @@
// assertion macros for the sorted key lower bound search block
`ifndef SORTED_KEY_LOWER_BOUND_SEARCH_DEFINES_SVH
`define SORTED_KEY_LOWER_BOUND_SEARCH_DEFINES_SVH

// same-cycle implication
`define SKLB_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SKLB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ sv/sklb_pkg.sv @@
// shared constants and types for the sorted key lower bound search block
package sklb_pkg;

	localparam int WORD_W        = 64;
	localparam int KEY_W         = 3 * WORD_W;
	localparam int IN_DATA_W     = KEY_W;
	localparam int IN_USER_W     = 2;
	localparam int POS_W         = 11;
	localparam int OUT_DATA_W    = 16;
	localparam int OUT_USER_W    = 1;
	localparam int DEFAULT_DEPTH = 1024;

	typedef enum logic [IN_USER_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

endpackage

@@ sv/sorted_key_lower_bound_search.sv @@
// sorted key table with append, clear and lower bound search over a key memory
//
// channel   dir  data                                        user
// s_*       in   key_high [63:0], key_mid, key_low [191:128]  operation [1:0]
// m_*       out  position [10:0], zero pad to 16              status [0]
//
// clear and append finish in the cycle of acceptance
// search bisects the stored entries, one key memory read per probe
// reset clears the entry count, the state and the output valid; the key memory is not cleared
// a finished result waits in a holding register while the output is stalled
// no new word is taken during a search or while a result waits in the holding register
module sorted_key_lower_bound_search #(
	parameter int TABLE_DEPTH = sklb_pkg::DEFAULT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sklb_pkg::IN_DATA_W-1:0]    s_tdata,  // key_high, key_mid, key_low
	input  logic [sklb_pkg::IN_USER_W-1:0]    s_tuser,  // operation
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sklb_pkg::OUT_DATA_W-1:0]   m_tdata,  // position, zero pad
	output logic [sklb_pkg::OUT_USER_W-1:0]   m_tuser   // status
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WIDE_W = (CNT_W > sklb_pkg::POS_W) ? CNT_W : sklb_pkg::POS_W;
	localparam int W      = sklb_pkg::WORD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_HOLD
	} state_t;

	state_t state_q;

	logic [sklb_pkg::KEY_W-1:0] key_mem_q [TABLE_DEPTH];
	logic [sklb_pkg::KEY_W-1:0] rd_data_q;
	logic [sklb_pkg::KEY_W-1:0] key_q;
	logic [sklb_pkg::KEY_W-1:0] in_key;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           lo_q;
	logic [CNT_W-1:0]           hi_q;
	logic [CNT_W-1:0]           mid_q;
	logic [CNT_W-1:0]           lo_n;
	logic [CNT_W-1:0]           hi_n;
	logic [CNT_W-1:0]           mid_n;
	logic [CNT_W-1:0]           mid_init;
	logic [CNT_W-1:0]           fin_cnt;
	logic [WIDE_W-1:0]          fin_wide;
	logic [sklb_pkg::POS_W-1:0] fin_pos;
	logic [sklb_pkg::POS_W-1:0] res_pos_q;
	logic [sklb_pkg::POS_W-1:0] m_pos_q;
	logic [ADDR_W-1:0]          rd_addr;
	logic                       res_status_q;
	logic                       m_status_q;
	logic                       m_tvalid_q;
	logic                       fin;
	logic                       fin_status;
	logic                       s_acc;
	logic                       is_full;
	logic                       less;
	logic                       more;
	logic                       slot_free;
	logic                       out_load;
	logic                       wr_en;
	sklb_pkg::op_t              in_op;

	assign s_acc     = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign in_op     = sklb_pkg::op_t'(s_tuser);
	assign in_key    = {s_tdata[W-1:0], s_tdata[2*W-1:W], s_tdata[3*W-1:2*W]};
	assign is_full   = (count_q == CNT_W'(TABLE_DEPTH));
	assign slot_free = !m_tvalid_q || m_tready;
	assign out_load  = slot_free && (fin || (state_q == S_HOLD));
	assign wr_en     = s_acc && (in_op == sklb_pkg::OP_APPEND) && !is_full;

	// one bisection step on the word read last cycle
	assign less     = (rd_data_q < key_q);
	assign lo_n     = less ? (mid_q + CNT_W'(1)) : lo_q;
	assign hi_n     = less ? hi_q : mid_q;
	assign more     = (lo_n < hi_n);
	assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);
	assign mid_init = count_q >> 1;
	assign rd_addr  = (state_q == S_IDLE) ? mid_init[ADDR_W-1:0] : mid_n[ADDR_W-1:0];

	always_comb begin
		fin        = 1'b0;
		fin_cnt    = '0;
		fin_status = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (in_op)
						sklb_pkg::OP_APPEND: begin
							fin        = 1'b1;
							fin_cnt    = count_q;
							fin_status = is_full;
						end
						sklb_pkg::OP_SEARCH: fin = (count_q == '0);
						default:             fin = 1'b1;
					endcase
				end
			end
			S_PROBE: begin
				fin     = !more;
				fin_cnt = lo_n;
			end
			default: ;
		endcase
	end

	assign fin_wide = WIDE_W'(fin_cnt);
	assign fin_pos  = fin_wide[sklb_pkg::POS_W-1:0];

	// key memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem_q[count_q[ADDR_W-1:0]] <= in_key;
		end
		rd_data_q <= key_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						key_q <= in_key;
						lo_q  <= '0;
						hi_q  <= count_q;
						mid_q <= mid_init;
						case (in_op)
							sklb_pkg::OP_CLEAR:  count_q <= '0;
							sklb_pkg::OP_APPEND: begin
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							sklb_pkg::OP_SEARCH: begin
								if (count_q != '0) begin
									state_q <= S_PROBE;
								end
							end
							default: ;
						endcase
					end
				end
				S_PROBE: begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
				end
				S_HOLD: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_pos_q    <= res_pos_q;
						m_status_q <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (fin) begin
				if (slot_free) begin
					m_tvalid_q <= 1'b1;
					m_pos_q    <= fin_pos;
					m_status_q <= fin_status;
					state_q    <= S_IDLE;
				end else begin
					res_pos_q    <= fin_pos;
					res_status_q <= fin_status;
					state_q      <= S_HOLD;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = sklb_pkg::OUT_DATA_W'(m_pos_q);
	assign m_tuser  = m_status_q;

endmodule

@@ sv/sklb_checker.sv @@
// port-level assertions for the sorted key lower bound search block
`include "sorted_key_lower_bound_search_defines.svh"

module sklb_checker #(
	parameter int TABLE_DEPTH = sklb_pkg::DEFAULT_DEPTH
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [sklb_pkg::IN_DATA_W-1:0]    s_tdata,
	input logic [sklb_pkg::IN_USER_W-1:0]    s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sklb_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [sklb_pkg::OUT_USER_W-1:0]   m_tuser
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words taken and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	`SKLB_ASSERT_NOW(a_no_spurious_result, clk, arst_n, m_tvalid, pend_q != 2'd0, "result without input word")
	`SKLB_ASSERT_NOW(a_two_pending_blocks, clk, arst_n, pend_q == 2'd2, !s_tready, "input taken with two words pending")
	`SKLB_ASSERT_NOW(a_full_position, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[sklb_pkg::POS_W-1:0] == sklb_pkg::POS_W'(TABLE_DEPTH), "full status with wrong position")
	`SKLB_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sorted_key_lower_bound_search sklb_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_sklb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
